>>> rtl/fan_tacho_and_pwm_controller_unit_defines.svh
// ----------------------------------------------------------------------------
// fan tacho and pwm controller assertion macros
// shared property wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef FAN_TACHO_AND_PWM_CONTROLLER_UNIT_DEFINES_SVH
`define FAN_TACHO_AND_PWM_CONTROLLER_UNIT_DEFINES_SVH

// property checked outside of reset
`define FTPC_ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property that also covers the reset cycles
`define FTPC_ASSERT(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/ftpc_pkg.sv
// ----------------------------------------------------------------------------
// ftpc_pkg
// types, constants and register codes of the fan tacho and pwm controller
// ----------------------------------------------------------------------------
package ftpc_pkg;

   // default build settings
   localparam int unsigned FTPC_FAN_COUNT          = 2;
   localparam int unsigned FTPC_EDGES_PER_TURN     = 2;
   localparam int unsigned FTPC_POTI_FULL_SCALE_MV = 3000;

   localparam int unsigned FAN_SLOTS   = 2;
   localparam int unsigned QUEUE_DEPTH = 2;

   localparam int unsigned TACHO_BASE = 60 * 1000;
   localparam int unsigned SPEED_MAX  = 32767;

   localparam int unsigned RPM_W      = 16;
   localparam int unsigned SPEED_W    = 15;
   localparam int unsigned TIME_W     = 32;
   localparam int unsigned MV_W       = 12;
   localparam int unsigned PERIOD_W   = 30;
   localparam int unsigned CSR_DATA_W = 30;
   localparam int unsigned CSR_IDX_W  = 3;

   // shared divider: dividend is left aligned, only the top steps bits are used
   localparam int unsigned DIV_W      = 48;
   localparam int unsigned DVS_W      = 32;
   localparam int unsigned STEP_W     = 6;
   localparam int unsigned PROD_W     = PERIOD_W + RPM_W;
   localparam int unsigned TGT_PROD_W = RPM_W + MV_W;

   localparam logic [RPM_W-1:0]    MAX_RPM_CH0_RST   = 16'd1800;
   localparam logic [RPM_W-1:0]    MAX_RPM_CH1_RST   = 16'd4000;
   localparam logic [RPM_W-1:0]    MIN_RPM_RST       = 16'd0;
   localparam logic [PERIOD_W-1:0] PWM_PERIOD_RST    = 30'd40000;
   localparam logic [RPM_W-1:0]    STALL_TIMEOUT_RST = 16'd1000;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MAX_RPM_CH0    = 3'd0,
      REG_MAX_RPM_CH1    = 3'd1,
      REG_MIN_RPM_CH0    = 3'd2,
      REG_MIN_RPM_CH1    = 3'd3,
      REG_PWM_PERIOD_CH0 = 3'd4,
      REG_PWM_PERIOD_CH1 = 3'd5,
      REG_STALL_TIMEOUT  = 3'd6
   } ftpc_reg_type;

   typedef enum logic {
      OP_TACHO_EDGE = 1'b0,
      OP_UPDATE     = 1'b1
   } ftpc_op_type;

   typedef struct packed {
      logic              opcode;
      logic              fan_index;
      logic [TIME_W-1:0] time_ms;
      logic [MV_W-1:0]   poti_mv;
   } ftpc_req_type;

   // classified item between front and back
   typedef struct packed {
      logic              is_update;
      logic              fan_index;
      logic [TIME_W-1:0] time_ms;
      logic [MV_W-1:0]   poti_mv;
   } ftpc_cmd_type;

   typedef struct packed {
      logic                out_fan;
      logic [SPEED_W-1:0]  measured_rpm;
      logic [RPM_W-1:0]    target_rpm;
      logic [PERIOD_W-1:0] pulse_ns;
      logic                pulse_valid;
      logic                stalled;
   } ftpc_rsp_type;

   typedef struct packed {
      logic [FAN_SLOTS-1:0][RPM_W-1:0]    max_rpm;
      logic [FAN_SLOTS-1:0][RPM_W-1:0]    min_rpm;
      logic [FAN_SLOTS-1:0][PERIOD_W-1:0] pwm_period_ns;
      logic [RPM_W-1:0]                   stall_timeout_ms;
   } ftpc_cfg_type;

   typedef struct packed {
      logic              start;
      logic [DIV_W-1:0]  dividend;
      logic [DVS_W-1:0]  divisor;
      logic [STEP_W-1:0] steps;
   } ftpc_div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } ftpc_div_rsp_type;

endpackage

>>> rtl/ftpc_fifo.sv
// ----------------------------------------------------------------------------
// ftpc_fifo
// small first-in first-out queue used between the block's stages
// ----------------------------------------------------------------------------
module ftpc_fifo #(
   parameter int unsigned WIDTH = 1,
   parameter int unsigned DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

>>> rtl/ftpc_csr.sv
// ----------------------------------------------------------------------------
// ftpc_csr
// configuration registers of both fan channels
// ----------------------------------------------------------------------------
module ftpc_csr
   import ftpc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output ftpc_cfg_type          cfg
);

   ftpc_cfg_type cfg_ff, cfg_in;

   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_MAX_RPM_CH0:    cfg_in.max_rpm[0]       = csr_wdata[RPM_W-1:0];
            REG_MAX_RPM_CH1:    cfg_in.max_rpm[1]       = csr_wdata[RPM_W-1:0];
            REG_MIN_RPM_CH0:    cfg_in.min_rpm[0]       = csr_wdata[RPM_W-1:0];
            REG_MIN_RPM_CH1:    cfg_in.min_rpm[1]       = csr_wdata[RPM_W-1:0];
            REG_PWM_PERIOD_CH0: cfg_in.pwm_period_ns[0] = csr_wdata[PERIOD_W-1:0];
            REG_PWM_PERIOD_CH1: cfg_in.pwm_period_ns[1] = csr_wdata[PERIOD_W-1:0];
            REG_STALL_TIMEOUT:  cfg_in.stall_timeout_ms = csr_wdata[RPM_W-1:0];
            default: begin
               // unknown index, write dropped
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_rpm[0]       <= MAX_RPM_CH0_RST;
         cfg_ff.max_rpm[1]       <= MAX_RPM_CH1_RST;
         cfg_ff.min_rpm[0]       <= MIN_RPM_RST;
         cfg_ff.min_rpm[1]       <= MIN_RPM_RST;
         cfg_ff.pwm_period_ns[0] <= PWM_PERIOD_RST;
         cfg_ff.pwm_period_ns[1] <= PWM_PERIOD_RST;
         cfg_ff.stall_timeout_ms <= STALL_TIMEOUT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> rtl/ftpc_div.sv
// ----------------------------------------------------------------------------
// ftpc_div
// shared restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ftpc_div
   import ftpc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  ftpc_div_req_type div_req,
   output ftpc_div_rsp_type div_rsp
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [DIV_W-1:0]  dvd_ff, dvd_in;
   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;
   logic [DVS_W:0]    trial;
   logic [DVS_W:0]    diff;
   logic              fits;

   assign trial = {rem_ff, dvd_ff[DIV_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = (trial >= {1'b0, dvs_ff});

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = div_req.steps;
         rem_in  = '0;
         dvd_in  = div_req.dividend;
         quo_in  = '0;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so the low bits always hold it
         rem_in = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
         dvd_in = {dvd_ff[DIV_W-2:0], 1'b0};
         quo_in = {quo_ff[DIV_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

endmodule

>>> rtl/ftpc_front.sv
// ----------------------------------------------------------------------------
// ftpc_front
// input side: drops items for absent channels, clamps the voltage
// ----------------------------------------------------------------------------
module ftpc_front
   import ftpc_pkg::*;
#(
   parameter int unsigned FAN_COUNT          = FTPC_FAN_COUNT,
   parameter int unsigned POTI_FULL_SCALE_MV = FTPC_POTI_FULL_SCALE_MV
) (
   input  logic         push,
   input  ftpc_req_type req_data,
   output logic         full,
   output logic         cmd_push,
   output ftpc_cmd_type cmd_data,
   input  logic         cmd_full
);

   localparam logic [MV_W-1:0] FullScale = MV_W'(POTI_FULL_SCALE_MV);

   logic fan_present;

   assign fan_present = (32'(req_data.fan_index) < FAN_COUNT);
   assign full        = cmd_full;
   // an item for an absent channel is taken and dropped here
   assign cmd_push    = push && !cmd_full && fan_present;

   assign cmd_data.is_update = (req_data.opcode == OP_UPDATE);
   assign cmd_data.fan_index = req_data.fan_index;
   assign cmd_data.time_ms   = req_data.time_ms;
   assign cmd_data.poti_mv   = (req_data.poti_mv > FullScale) ? FullScale : req_data.poti_mv;

endmodule

>>> rtl/ftpc_back.sv
// ----------------------------------------------------------------------------
// ftpc_back
// per-channel speed and target sequencer around the shared divider
// ----------------------------------------------------------------------------
module ftpc_back
   import ftpc_pkg::*;
#(
   parameter int unsigned EDGES_PER_TURN     = FTPC_EDGES_PER_TURN,
   parameter int unsigned POTI_FULL_SCALE_MV = FTPC_POTI_FULL_SCALE_MV
) (
   input  logic             clock,
   input  logic             reset,
   input  ftpc_cfg_type     cfg,
   input  logic             cmd_empty,
   input  ftpc_cmd_type     cmd_data,
   output logic             cmd_pop,
   input  logic             rsp_full,
   output logic             rsp_push,
   output ftpc_rsp_type     rsp_data,
   output ftpc_div_req_type div_req,
   input  ftpc_div_rsp_type div_rsp
);

   localparam int unsigned        TachoNum    = TACHO_BASE / EDGES_PER_TURN;
   localparam logic [RPM_W-1:0]   TachoBits   = RPM_W'(TachoNum);
   localparam logic [SPEED_W-1:0] TachoSat    =
      (TachoNum > SPEED_MAX) ? SPEED_W'(SPEED_MAX) : SPEED_W'(TachoNum);
   localparam int unsigned        RecipW      = TGT_PROD_W + 1;
   localparam int unsigned        RecipProdW  = TGT_PROD_W + RecipW;
   // reciprocal of the full-scale voltage, scaled by 2^TGT_PROD_W
   localparam logic [RecipW-1:0]  RecipFull   =
      RecipW'((64'd1 << TGT_PROD_W) / POTI_FULL_SCALE_MV);
   localparam logic [TGT_PROD_W-1:0] FullScale = TGT_PROD_W'(POTI_FULL_SCALE_MV);
   localparam logic [STEP_W-1:0]  EdgeSteps   = STEP_W'(RPM_W);
   localparam logic [STEP_W-1:0]  PulseSteps  = STEP_W'(PROD_W);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_EDGE_WAIT,
      ST_TGT_START,
      ST_TGT_WAIT,
      ST_TGT_FIX,
      ST_PULSE_MUL,
      ST_PULSE_START,
      ST_PULSE_WAIT,
      ST_EMIT
   } state_type;

   state_type          state_ff, state_in;
   ftpc_cmd_type       cmd_ff, cmd_in;
   ftpc_rsp_type       rsp_ff, rsp_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [RPM_W-1:0]   tq_ff, tq_in;
   logic [TIME_W-1:0]  last_edge_ff [FAN_SLOTS];
   logic [TIME_W-1:0]  last_edge_in [FAN_SLOTS];
   logic [SPEED_W-1:0] speed_ff [FAN_SLOTS];
   logic [SPEED_W-1:0] speed_in [FAN_SLOTS];
   logic [RPM_W-1:0]   goal_ff [FAN_SLOTS];
   logic [RPM_W-1:0]   goal_in [FAN_SLOTS];

   logic                  ch;
   logic [TIME_W-1:0]     delta;
   logic                  stall_hit;
   logic [RecipProdW-1:0] recip_prod;
   logic [TGT_PROD_W-1:0] tq_back;
   logic [RPM_W-1:0]      tgt_q;
   logic [RPM_W-1:0]      goal_v;
   logic [PERIOD_W-1:0]   period;
   logic [RPM_W-1:0]      max_rpm;

   assign ch         = cmd_ff.fan_index;
   assign delta      = cmd_ff.time_ms - last_edge_ff[ch];
   assign stall_hit  = (speed_ff[ch] != '0) && (delta > TIME_W'(cfg.stall_timeout_ms));
   assign recip_prod = RecipProdW'(prod_ff[TGT_PROD_W-1:0]) * RecipProdW'(RecipFull);
   assign tq_back    = TGT_PROD_W'(tq_ff) * FullScale;
   // estimate is at most one low, the remainder in prod_ff tells
   assign tgt_q      = (prod_ff[TGT_PROD_W-1:0] >= FullScale) ? tq_ff + 1'b1 : tq_ff;
   assign goal_v     = (tgt_q < cfg.min_rpm[ch]) ? cfg.min_rpm[ch] : tgt_q;
   assign period     = cfg.pwm_period_ns[ch];
   assign max_rpm    = cfg.max_rpm[ch];
   assign rsp_data   = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      rsp_in       = rsp_ff;
      prod_in      = prod_ff;
      tq_in        = tq_ff;
      last_edge_in = last_edge_ff;
      speed_in     = speed_ff;
      goal_in      = goal_ff;
      cmd_pop      = 1'b0;
      rsp_push     = 1'b0;
      div_req      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop  = 1'b1;
               cmd_in   = cmd_data;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            rsp_in.out_fan      = ch;
            rsp_in.measured_rpm = speed_ff[ch];
            rsp_in.target_rpm   = goal_ff[ch];
            rsp_in.pulse_ns     = '0;
            rsp_in.pulse_valid  = 1'b0;
            rsp_in.stalled      = 1'b0;
            if (!cmd_ff.is_update) begin
               last_edge_in[ch] = cmd_ff.time_ms;
               if (delta == '0) begin
                  speed_in[ch]        = TachoSat;
                  rsp_in.measured_rpm = TachoSat;
                  state_in            = ST_EMIT;
               end else begin
                  div_req.start    = 1'b1;
                  div_req.dividend = {TachoBits, {(DIV_W - RPM_W){1'b0}}};
                  div_req.divisor  = delta;
                  div_req.steps    = EdgeSteps;
                  state_in         = ST_EDGE_WAIT;
               end
            end else begin
               rsp_in.pulse_valid = 1'b1;
               prod_in = PROD_W'(max_rpm) * PROD_W'(cmd_ff.poti_mv);
               if (stall_hit) begin
                  speed_in[ch]        = '0;
                  rsp_in.measured_rpm = '0;
                  rsp_in.stalled      = 1'b1;
               end
               state_in = ST_TGT_START;
            end
         end
         ST_EDGE_WAIT: begin
            if (div_rsp.done) begin
               if (div_rsp.quotient > DIV_W'(SPEED_MAX)) begin
                  speed_in[ch]        = SPEED_W'(SPEED_MAX);
                  rsp_in.measured_rpm = SPEED_W'(SPEED_MAX);
               end else begin
                  speed_in[ch]        = div_rsp.quotient[SPEED_W-1:0];
                  rsp_in.measured_rpm = div_rsp.quotient[SPEED_W-1:0];
               end
               state_in = ST_EMIT;
            end
         end
         ST_TGT_START: begin
            // quotient estimate by the full-scale reciprocal
            tq_in    = recip_prod[TGT_PROD_W +: RPM_W];
            state_in = ST_TGT_WAIT;
         end
         ST_TGT_WAIT: begin
            prod_in  = PROD_W'(prod_ff[TGT_PROD_W-1:0] - tq_back);
            state_in = ST_TGT_FIX;
         end
         ST_TGT_FIX: begin
            goal_in[ch]       = goal_v;
            rsp_in.target_rpm = goal_v;
            state_in          = ST_PULSE_MUL;
         end
         ST_PULSE_MUL: begin
            prod_in = PROD_W'(period) * PROD_W'(goal_ff[ch]);
            if (max_rpm == '0) begin
               // no full scale: all or nothing
               rsp_in.pulse_ns = (goal_ff[ch] != '0) ? period : '0;
               state_in        = ST_EMIT;
            end else begin
               state_in = ST_PULSE_START;
            end
         end
         ST_PULSE_START: begin
            div_req.start    = 1'b1;
            div_req.dividend = {prod_ff, {(DIV_W - PROD_W){1'b0}}};
            div_req.divisor  = DVS_W'(max_rpm);
            div_req.steps    = PulseSteps;
            state_in         = ST_PULSE_WAIT;
         end
         ST_PULSE_WAIT: begin
            if (div_rsp.done) begin
               // target above full scale saturates at the period
               if (div_rsp.quotient > DIV_W'(period)) begin
                  rsp_in.pulse_ns = period;
               end else begin
                  rsp_in.pulse_ns = div_rsp.quotient[PERIOD_W-1:0];
               end
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         last_edge_ff <= '{default: '0};
         speed_ff     <= '{default: '0};
         goal_ff      <= '{default: '0};
      end else begin
         state_ff     <= state_in;
         last_edge_ff <= last_edge_in;
         speed_ff     <= speed_in;
         goal_ff      <= goal_in;
         cmd_ff       <= cmd_in;
         rsp_ff       <= rsp_in;
         prod_ff      <= prod_in;
         tq_ff        <= tq_in;
      end
   end

endmodule

>>> rtl/fan_tacho_and_pwm_controller_unit.sv
// ----------------------------------------------------------------------------
// fan_tacho_and_pwm_controller_unit
// two-channel fan tacho speed measurement and pwm pulse length controller
// ----------------------------------------------------------------------------
// a tacho edge takes 16 steps and an update 46 of the bit-serial divider that
// the back end shares; a zero interval or a zero full scale skips the divider
// flow: the back end takes one item at a time, the next once the last result
// is queued; two more wait in the input queue, two results in the output queue
// reset: synchronous; clears queues, channel state and loads register defaults
module fan_tacho_and_pwm_controller_unit
   import ftpc_pkg::*;
#(
   parameter int unsigned FAN_COUNT          = FTPC_FAN_COUNT,
   parameter int unsigned EDGES_PER_TURN     = FTPC_EDGES_PER_TURN,
   parameter int unsigned POTI_FULL_SCALE_MV = FTPC_POTI_FULL_SCALE_MV
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  ftpc_req_type          req_data,
   output logic                  full,
   output logic                  empty,
   input  logic                  pop,
   output ftpc_rsp_type          rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int unsigned CmdW = $bits(ftpc_cmd_type);
   localparam int unsigned RspW = $bits(ftpc_rsp_type);

   ftpc_cfg_type     cfg;
   logic             cmd_push;
   ftpc_cmd_type     cmd_wdata;
   logic             cmd_full;
   logic             cmd_pop;
   logic             cmd_empty;
   logic [CmdW-1:0]  cmd_rdata;
   logic             rsp_push;
   ftpc_rsp_type     rsp_wdata;
   logic             rsp_full;
   logic [RspW-1:0]  rsp_rdata;
   ftpc_div_req_type div_req;
   ftpc_div_rsp_type div_rsp;

   assign rsp_data = ftpc_rsp_type'(rsp_rdata);

   ftpc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ftpc_front #(
      .FAN_COUNT          (FAN_COUNT),
      .POTI_FULL_SCALE_MV (POTI_FULL_SCALE_MV)
   ) u_front (
      .push     (push),
      .req_data (req_data),
      .full     (full),
      .cmd_push (cmd_push),
      .cmd_data (cmd_wdata),
      .cmd_full (cmd_full)
   );

   ftpc_fifo #(
      .WIDTH (CmdW),
      .DEPTH (QUEUE_DEPTH)
   ) u_cmd_fifo (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .wdata (cmd_wdata),
      .full  (cmd_full),
      .pop   (cmd_pop),
      .rdata (cmd_rdata),
      .empty (cmd_empty)
   );

   ftpc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   ftpc_back #(
      .EDGES_PER_TURN     (EDGES_PER_TURN),
      .POTI_FULL_SCALE_MV (POTI_FULL_SCALE_MV)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd_empty (cmd_empty),
      .cmd_data  (ftpc_cmd_type'(cmd_rdata)),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_wdata),
      .div_req   (div_req),
      .div_rsp   (div_rsp)
   );

   ftpc_fifo #(
      .WIDTH (RspW),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .wdata (rsp_wdata),
      .full  (rsp_full),
      .pop   (pop),
      .rdata (rsp_rdata),
      .empty (empty)
   );

endmodule

>>> rtl/ftpc_checker.sv
// ----------------------------------------------------------------------------
// ftpc_checker
// port-level checks of the fan tacho and pwm controller
// ----------------------------------------------------------------------------
`include "fan_tacho_and_pwm_controller_unit_defines.svh"

module ftpc_checker
   import ftpc_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         full,
   input logic         empty,
   input logic         pop,
   input ftpc_rsp_type rsp_data
);

   // waiting result holds until its transfer
   `FTPC_ASSERT_RST(a_rsp_hold, clock, reset, (!empty && !pop) |=> (!empty && $stable(rsp_data)), "result changed before transfer")

   `FTPC_ASSERT(a_reset_clear, clock, reset |=> (empty && !full), "queues not clear after reset")

   // a stall only comes from an update and always zeroes the speed
   `FTPC_ASSERT_RST(a_stall_speed, clock, reset, (!empty && rsp_data.stalled) |-> (rsp_data.pulse_valid && rsp_data.measured_rpm == '0), "stall result with speed")

   `FTPC_ASSERT_RST(a_edge_pulse, clock, reset, (!empty && !rsp_data.pulse_valid) |-> (rsp_data.pulse_ns == '0), "edge result with pulse length")

endmodule

bind fan_tacho_and_pwm_controller_unit ftpc_checker u_ftpc_checker (.*);

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// two-channel fan tacho and pwm controller: directed corner items, then
// random fan activity under several register settings, each transfer
// checked field by field against a behavioral model of the channel state
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import ftpc_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 800000;
   localparam int unsigned DRAIN_CYCLES = 100;
   localparam int unsigned IDLE_PCT = 18;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 3'd7;
   localparam int unsigned TACHO_NUM = TACHO_BASE / FTPC_EDGES_PER_TURN;
   localparam int unsigned FULL_MV = FTPC_POTI_FULL_SCALE_MV;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   ftpc_req_type req_data = '0;
   logic full;
   logic empty;
   logic pop = 1'b0;
   ftpc_rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // register copy and channel state of the model
   logic [RPM_W-1:0] cfg_max_rpm [2];
   logic [RPM_W-1:0] cfg_min_rpm [2];
   logic [PERIOD_W-1:0] cfg_period_ns [2];
   logic [RPM_W-1:0] cfg_stall_ms;
   logic [TIME_W-1:0] edge_ms [2];
   logic [SPEED_W-1:0] speed_rpm [2];
   logic [RPM_W-1:0] goal_rpm [2];

   // stimulus generator view of each channel's timeline
   logic [TIME_W-1:0] gen_time [2];
   logic [TIME_W-1:0] gen_edge [2];

   ftpc_req_type pending_items [$];
   ftpc_rsp_type due_status [$];
   logic steady = 1'b0;
   int n_errors = 0;
   int n_edges = 0;
   int n_updates = 0;
   int n_stalls = 0;
   int n_settings = 0;
   int n_results = 0;

   fan_tacho_and_pwm_controller_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .req_data  (req_data),
      .full      (full),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic ftpc_rsp_type predict_fan_status(ftpc_req_type item);
      ftpc_rsp_type res;
      logic ch;
      logic [TIME_W-1:0] delta;
      logic [63:0] spd;
      logic [63:0] mv;
      logic [63:0] tgt;
      logic [63:0] pulse;
      res = '0;
      ch = item.fan_index;
      delta = item.time_ms - edge_ms[ch];
      if (item.opcode == OP_TACHO_EDGE) begin
         spd = (delta == '0) ? 64'(TACHO_NUM) : 64'(TACHO_NUM / delta);
         if (spd > 64'(SPEED_MAX)) spd = 64'(SPEED_MAX);
         speed_rpm[ch] = spd[SPEED_W-1:0];
         edge_ms[ch] = item.time_ms;
         n_edges++;
      end else begin
         if (speed_rpm[ch] != '0 && delta > TIME_W'(cfg_stall_ms)) begin
            speed_rpm[ch] = '0;
            res.stalled = 1'b1;
            n_stalls++;
         end
         mv = (item.poti_mv > MV_W'(FULL_MV)) ? 64'(FULL_MV) : 64'(item.poti_mv);
         tgt = (64'(cfg_max_rpm[ch]) * mv) / 64'(FULL_MV);
         if (tgt < 64'(cfg_min_rpm[ch])) tgt = 64'(cfg_min_rpm[ch]);
         goal_rpm[ch] = tgt[RPM_W-1:0];
         if (cfg_max_rpm[ch] == '0)
            pulse = (goal_rpm[ch] != '0) ? 64'(cfg_period_ns[ch]) : 64'd0;
         else
            pulse = (64'(cfg_period_ns[ch]) * 64'(goal_rpm[ch])) / 64'(cfg_max_rpm[ch]);
         if (pulse > 64'(cfg_period_ns[ch])) pulse = 64'(cfg_period_ns[ch]);
         res.pulse_ns = pulse[PERIOD_W-1:0];
         res.pulse_valid = 1'b1;
         n_updates++;
      end
      res.out_fan = ch;
      res.measured_rpm = speed_rpm[ch];
      res.target_rpm = goal_rpm[ch];
      return res;
   endfunction

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         n_errors++;
      end
   endtask

   // sender: presents queued items, holds while full
   always @(posedge clock) begin : driver
      logic go;
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full) due_status.push_back(predict_fan_status(req_data));
         if (push && full) begin
            go = 1'b1;
         end else if (pending_items.size() > 0 &&
                      (steady || $urandom_range(99) >= IDLE_PCT)) begin
            go = 1'b1;
            req_data <= pending_items.pop_front();
         end else begin
            go = 1'b0;
         end
         push <= go;
      end
   end

   // receiver: checks each result transfer against the oldest prediction
   always @(posedge clock) begin : monitor
      ftpc_rsp_type want;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            n_results++;
            if (due_status.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %p", $time, rsp_data);
               n_errors++;
            end else begin
               want = due_status.pop_front();
               check_field("out_fan", 64'(want.out_fan), 64'(rsp_data.out_fan));
               check_field("measured_rpm", 64'(want.measured_rpm),
                           64'(rsp_data.measured_rpm));
               check_field("target_rpm", 64'(want.target_rpm), 64'(rsp_data.target_rpm));
               check_field("pulse_ns", 64'(want.pulse_ns), 64'(rsp_data.pulse_ns));
               check_field("pulse_valid", 64'(want.pulse_valid), 64'(rsp_data.pulse_valid));
               check_field("stalled", 64'(want.stalled), 64'(rsp_data.stalled));
            end
         end
         pop <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         REG_MAX_RPM_CH0:    cfg_max_rpm[0] = val[RPM_W-1:0];
         REG_MAX_RPM_CH1:    cfg_max_rpm[1] = val[RPM_W-1:0];
         REG_MIN_RPM_CH0:    cfg_min_rpm[0] = val[RPM_W-1:0];
         REG_MIN_RPM_CH1:    cfg_min_rpm[1] = val[RPM_W-1:0];
         REG_PWM_PERIOD_CH0: cfg_period_ns[0] = val[PERIOD_W-1:0];
         REG_PWM_PERIOD_CH1: cfg_period_ns[1] = val[PERIOD_W-1:0];
         REG_STALL_TIMEOUT:  cfg_stall_ms = val[RPM_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_fan_regs(input logic [RPM_W-1:0] m0, input logic [RPM_W-1:0] m1,
                               input logic [RPM_W-1:0] n0, input logic [RPM_W-1:0] n1,
                               input logic [PERIOD_W-1:0] p0, input logic [PERIOD_W-1:0] p1,
                               input logic [RPM_W-1:0] st);
      write_reg(REG_MAX_RPM_CH0, CSR_DATA_W'(m0));
      write_reg(REG_MAX_RPM_CH1, CSR_DATA_W'(m1));
      write_reg(REG_MIN_RPM_CH0, CSR_DATA_W'(n0));
      write_reg(REG_MIN_RPM_CH1, CSR_DATA_W'(n1));
      write_reg(REG_PWM_PERIOD_CH0, CSR_DATA_W'(p0));
      write_reg(REG_PWM_PERIOD_CH1, CSR_DATA_W'(p1));
      write_reg(REG_STALL_TIMEOUT, CSR_DATA_W'(st));
      // nonexistent register, must leave everything alone
      write_reg(REG_UNUSED, CSR_DATA_W'($urandom()));
      @(posedge clock);
      csr_we <= 1'b0;
      n_settings++;
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_items.size() != 0 || push || due_status.size() != 0);
   endtask

   task automatic add_item(input ftpc_op_type op, input logic ch,
                           input logic [TIME_W-1:0] t, input logic [MV_W-1:0] mv);
      ftpc_req_type it;
      it.opcode = op;
      it.fan_index = ch;
      it.time_ms = t;
      it.poti_mv = mv;
      pending_items.push_back(it);
   endtask

   // mostly plausible fan timelines, with jumps, repeats, wraps and noise
   task automatic add_random_items(input int count);
      logic ch;
      int sel;
      logic [TIME_W-1:0] t;
      ftpc_op_type op;
      logic [MV_W-1:0] mv;
      for (int i = 0; i < count; i++) begin
         ch = 1'($urandom_range(1, 0));
         op = ($urandom_range(99) < 55) ? OP_TACHO_EDGE : OP_UPDATE;
         sel = $urandom_range(99);
         if (sel < 8)
            t = $urandom();
         else if (sel < 16)
            t = gen_time[ch] + $urandom_range(70000, 500);
         else if (sel < 22)
            t = gen_edge[ch] + TIME_W'(cfg_stall_ms) + $urandom_range(1, 0);
         else if (sel < 26)
            t = 32'hFFFF_FFFF - $urandom_range(40, 0);
         else if (sel < 31)
            t = gen_time[ch];
         else
            t = gen_time[ch] + $urandom_range(120, 1);
         sel = $urandom_range(99);
         if (sel < 10)
            mv = '0;
         else if (sel < 20)
            mv = MV_W'(FULL_MV);
         else if (sel < 28)
            mv = '1;
         else
            mv = MV_W'($urandom_range(4095, 0));
         gen_time[ch] = t;
         if (op == OP_TACHO_EDGE) gen_edge[ch] = t;
         add_item(op, ch, t, mv);
      end
   endtask

   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("%0t: timeout, %0d results still due", $time, due_status.size());
      $display("testbench: done, errors");
      $finish;
   end

   initial begin : stimulus
      cfg_max_rpm[0] = MAX_RPM_CH0_RST;
      cfg_max_rpm[1] = MAX_RPM_CH1_RST;
      cfg_min_rpm[0] = MIN_RPM_RST;
      cfg_min_rpm[1] = MIN_RPM_RST;
      cfg_period_ns[0] = PWM_PERIOD_RST;
      cfg_period_ns[1] = PWM_PERIOD_RST;
      cfg_stall_ms = STALL_TIMEOUT_RST;
      for (int c = 0; c < 2; c++) begin
         edge_ms[c] = '0;
         speed_rpm[c] = '0;
         goal_rpm[c] = '0;
         gen_time[c] = '0;
         gen_edge[c] = '0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // register defaults: first edge, zero interval, wrap, stall boundary
      add_item(OP_TACHO_EDGE, 1'b0, 32'd0, 12'd0);
      add_item(OP_TACHO_EDGE, 1'b0, 32'd1, 12'd0);
      add_item(OP_TACHO_EDGE, 1'b0, 32'd3, 12'd0);
      add_item(OP_TACHO_EDGE, 1'b0, 32'd63, 12'd0);
      add_item(OP_UPDATE, 1'b0, 32'd1063, 12'd3000);
      add_item(OP_UPDATE, 1'b0, 32'd1064, 12'hFFF);
      add_item(OP_UPDATE, 1'b0, 32'd1065, 12'd0);
      add_item(OP_TACHO_EDGE, 1'b1, 32'hFFFF_FFFF, 12'd0);
      add_item(OP_TACHO_EDGE, 1'b1, 32'd9, 12'd0);
      add_item(OP_UPDATE, 1'b1, 32'hFFFF_FFF0, 12'd1500);
      add_item(OP_UPDATE, 1'b1, 32'hFFFF_FFF1, 12'hFFF);
      add_item(OP_TACHO_EDGE, 1'b1, 32'd20, 12'd0);
      add_item(OP_UPDATE, 1'b1, 32'd20, 12'd1);
      add_item(OP_TACHO_EDGE, 1'b0, 32'hFFFF_FFFF, 12'hFFF);
      wait_drained();

      // zero full scale with a floor, floor above full scale, zero timeout
      set_fan_regs(16'd0, 16'd1000, 16'd500, 16'd2000, 30'd1000000000, 30'd1, 16'd0);
      add_item(OP_UPDATE, 1'b0, 32'd5, 12'd2999);
      add_item(OP_UPDATE, 1'b1, 32'd5, 12'd3000);
      add_item(OP_TACHO_EDGE, 1'b1, 32'd100, 12'd0);
      add_item(OP_UPDATE, 1'b1, 32'd100, 12'd4);
      add_item(OP_UPDATE, 1'b1, 32'd101, 12'd4);
      wait_drained();
      set_fan_regs(16'd0, 16'd1000, 16'd0, 16'd0, 30'd777, 30'd40000, 16'd0);
      add_item(OP_UPDATE, 1'b0, 32'd7, 12'hFFF);
      wait_drained();

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: set_fan_regs(MAX_RPM_CH0_RST, MAX_RPM_CH1_RST, MIN_RPM_RST, MIN_RPM_RST,
                            PWM_PERIOD_RST, PWM_PERIOD_RST, STALL_TIMEOUT_RST);
            1: set_fan_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0,
                            30'h3FFF_FFFF, 30'd1000000000, 16'hFFFF);
            2: set_fan_regs(16'd1, 16'd1, 16'd0, 16'd0, 30'd1, 30'd1, 16'd0);
            3: set_fan_regs(16'd0, RPM_W'($urandom_range(2000, 1)),
                            16'd0, RPM_W'($urandom_range(4000, 0)),
                            PERIOD_W'($urandom_range(100000, 1)),
                            PERIOD_W'($urandom_range(100000, 1)),
                            RPM_W'($urandom_range(300, 0)));
            default: set_fan_regs(RPM_W'($urandom_range(65535, 1)),
                                  RPM_W'($urandom_range(65535, 1)),
                                  RPM_W'($urandom_range(300, 0)),
                                  RPM_W'($urandom_range(65535, 0)),
                                  PERIOD_W'($urandom_range(1000000000, 1)),
                                  PERIOD_W'($urandom_range(1000000000, 1)),
                                  RPM_W'($urandom_range(2000, 0)));
         endcase
         // one setting runs with both sides streaming, no idle cycles
         steady = (ph == 2);
         add_random_items(185);
         wait_drained();
         steady = 1'b0;
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("testbench: %0d tacho edges and %0d updates checked, %0d of them stall clears",
               n_edges, n_updates, n_stalls);
      $display("testbench: %0d register settings, %0d result transfers compared",
               n_settings, n_results);
      if (n_errors == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule
